/* src/ptpd_pkg.sv */
package ptpd_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned NUM_REGS      = 8;
  localparam int unsigned REG_IDX_W     = 3;
  localparam int unsigned LANES         = 3;
  // quotient bits kept by the divider: 32 result bits plus one overflow bit
  localparam int unsigned QBITS         = 33;
  // scaled dividend width; the magnitude width is DIV_W - FRAC_BITS
  localparam int unsigned DIV_W         = 66;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ROW0_C01 = 3'd0,
    REG_ROW0_C23 = 3'd1,
    REG_ROW1_C01 = 3'd2,
    REG_ROW1_C23 = 3'd3,
    REG_ROW2_C01 = 3'd4,
    REG_ROW2_C23 = 3'd5,
    REG_ROW3_C01 = 3'd6,
    REG_ROW3_C23 = 3'd7
  } ptpd_reg_e;

  typedef struct packed {
    logic             w_zero;
    logic [LANES-1:0] neg;
    logic [LANES-1:0] ovf;
  } ptpd_ctrl_t;

  // identity matrix, with 1.0 = 1 << frac
  function automatic logic [63:0] reg_reset(ptpd_reg_e idx, int unsigned frac);
    logic [63:0] one;
    one = 64'(1) << frac;
    case (idx)
      REG_ROW0_C01: return one;
      REG_ROW1_C01: return one << 32;
      REG_ROW2_C23: return one;
      REG_ROW3_C23: return one << 32;
      default:      return 64'd0;
    endcase
  endfunction

endpackage

/* src/ptpd_regs.sv */
module ptpd_regs #(
  parameter int unsigned FRAC_BITS = ptpd_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  output logic signed [31:0] coef_o [4][4]
);
  import ptpd_pkg::*;

  logic [63:0]          mat_q [NUM_REGS];
  logic [REG_IDX_W-1:0] idx;

  assign idx    = paddr[5:3];
  assign pready = 1'b1;
  assign prdata = mat_q[idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        mat_q[i] <= reg_reset(ptpd_reg_e'(REG_IDX_W'(i)), FRAC_BITS);
      end
    end else if (psel && penable && pwrite) begin
      mat_q[idx] <= pwdata;
    end
  end

  // unpack: row r, column c sits in register 2r + c/2, low half for even c
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        coef_o[r][c] = (c % 2 == 1) ? mat_q[r*2 + c/2][63:32] : mat_q[r*2 + c/2][31:0];
      end
    end
  end

endmodule

/* src/ptpd_xform.sv */
module ptpd_xform #(
  parameter int unsigned FRAC_BITS = ptpd_pkg::FRAC_BITS_DEF,
  parameter int unsigned MW        = ptpd_pkg::DIV_W - FRAC_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic signed [31:0]          in_x_i,
  input  logic signed [31:0]          in_y_i,
  input  logic signed [31:0]          in_z_i,
  input  logic signed [31:0]          coef_i [4][4],
  output logic                        valid_o,
  output ptpd_pkg::ptpd_ctrl_t        ctrl_o,
  output logic [MW-1:0]               md_o,
  output logic [MW-1:0]               r0_o  [ptpd_pkg::LANES],
  output logic [ptpd_pkg::QBITS-1:0]  dlo_o [ptpd_pkg::LANES]
);
  import ptpd_pkg::*;

  // stage 1: twelve products, row-3 terms
  logic                v1_q;
  logic signed [63:0]  p_q  [3][4];
  logic signed [31:0]  c3_q [4];
  // stage 2: homogeneous columns
  logic                v2_q;
  logic signed [MW-1:0] col_q [4];
  logic signed [MW-1:0] col_d [4];
  // stage 3: divider setup
  logic                v3_q;
  ptpd_ctrl_t          ctrl_q, ctrl_d;
  logic [MW-1:0]       md_q, md_d;
  logic [MW-1:0]       r0_q  [LANES];
  logic [MW-1:0]       r0_d  [LANES];
  logic [QBITS-1:0]    dlo_q [LANES];
  logic [QBITS-1:0]    dlo_d [LANES];
  logic signed [31:0]  pt [3];

  assign pt[0] = in_x_i;
  assign pt[1] = in_y_i;
  assign pt[2] = in_z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 4; j++) begin
          p_q[k][j] <= 64'(pt[k]) * 64'(coef_i[k][j]);
        end
      end
      for (int j = 0; j < 4; j++) begin
        c3_q[j] <= coef_i[3][j];
      end
      col_q  <= col_d;
      ctrl_q <= ctrl_d;
      md_q   <= md_d;
      r0_q   <= r0_d;
      dlo_q  <= dlo_d;
    end
  end

  // floor each product to the fixed-point grid and add the translation term
  always_comb begin
    logic signed [63:0] sum;
    for (int j = 0; j < 4; j++) begin
      sum = 64'(c3_q[j]) + (p_q[0][j] >>> FRAC_BITS) + (p_q[1][j] >>> FRAC_BITS)
          + (p_q[2][j] >>> FRAC_BITS);
      col_d[j] = sum[MW-1:0];
    end
  end

  // split into sign and magnitude; the top quotient bits are checked up front
  always_comb begin
    logic [MW-1:0]    mn;
    logic [DIV_W-1:0] num;
    md_d          = col_q[3][MW-1] ? MW'(-col_q[3]) : MW'(col_q[3]);
    ctrl_d.w_zero = (col_q[3] == '0);
    for (int l = 0; l < LANES; l++) begin
      mn             = col_q[l][MW-1] ? MW'(-col_q[l]) : MW'(col_q[l]);
      num            = DIV_W'(mn) << FRAC_BITS;
      ctrl_d.neg[l]  = col_q[l][MW-1] ^ col_q[3][MW-1];
      ctrl_d.ovf[l]  = MW'(num[DIV_W-1:QBITS]) >= md_d;
      r0_d[l]        = MW'(num[DIV_W-1:QBITS]);
      dlo_d[l]       = num[QBITS-1:0];
    end
  end

  assign valid_o = v3_q;
  assign ctrl_o  = ctrl_q;
  assign md_o    = md_q;
  assign r0_o    = r0_q;
  assign dlo_o   = dlo_q;

endmodule

/* src/ptpd_div.sv */
module ptpd_div #(
  parameter int unsigned FRAC_BITS = ptpd_pkg::FRAC_BITS_DEF,
  parameter int unsigned MW        = ptpd_pkg::DIV_W - FRAC_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  ptpd_pkg::ptpd_ctrl_t        ctrl_i,
  input  logic [MW-1:0]               md_i,
  input  logic [MW-1:0]               r0_i  [ptpd_pkg::LANES],
  input  logic [ptpd_pkg::QBITS-1:0]  dlo_i [ptpd_pkg::LANES],
  output logic                        valid_o,
  output logic signed [31:0]          out_x_o,
  output logic signed [31:0]          out_y_o,
  output logic signed [31:0]          out_z_o,
  output logic                        w_was_zero_o,
  output logic                        clipped_o
);
  import ptpd_pkg::*;

  logic             v_q    [QBITS];
  ptpd_ctrl_t       ctrl_q [QBITS];
  logic [MW-1:0]    md_q   [QBITS];
  logic [MW-1:0]    r_q    [QBITS][LANES];
  logic [QBITS-1:0] d_q    [QBITS][LANES];
  logic [QBITS-1:0] q_q    [QBITS][LANES];

  for (genvar s = 0; s < QBITS; s++) begin : g_stage
    logic             pv;
    ptpd_ctrl_t       pctrl;
    logic [MW-1:0]    pmd;
    logic [MW-1:0]    pr [LANES];
    logic [QBITS-1:0] pd [LANES];
    logic [QBITS-1:0] pq [LANES];
    logic [MW-1:0]    r_d [LANES];
    logic [QBITS-1:0] q_d [LANES];

    if (s == 0) begin : g_head
      assign pv    = valid_i;
      assign pctrl = ctrl_i;
      assign pmd   = md_i;
      assign pr    = r0_i;
      assign pd    = dlo_i;
      for (genvar l = 0; l < LANES; l++) begin : g_q0
        assign pq[l] = '0;
      end
    end else begin : g_body
      assign pv    = v_q[s-1];
      assign pctrl = ctrl_q[s-1];
      assign pmd   = md_q[s-1];
      assign pr    = r_q[s-1];
      assign pd    = d_q[s-1];
      assign pq    = q_q[s-1];
    end

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
      logic [MW:0]   rs;
      logic [MW+1:0] diff;
      for (int l = 0; l < LANES; l++) begin
        rs     = {pr[l], pd[l][QBITS-1]};
        diff   = (MW+2)'(rs) - (MW+2)'(pmd);
        r_d[l] = diff[MW+1] ? rs[MW-1:0] : diff[MW-1:0];
        q_d[l] = {pq[l][QBITS-2:0], ~diff[MW+1]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ctrl_q[s] <= pctrl;
        md_q[s]   <= pmd;
        r_q[s]    <= r_d;
        q_q[s]    <= q_d;
        for (int l = 0; l < LANES; l++) begin
          d_q[s][l] <= pd[l] << 1;
        end
      end
    end
  end

  // sign, saturation and zero-w forcing
  logic              fv_q;
  logic signed [31:0] res_q [LANES];
  logic signed [31:0] res_d [LANES];
  logic              wz_q, clip_q, clip_d;

  always_comb begin
    logic [QBITS-1:0] qv;
    logic             sat;
    ptpd_ctrl_t       c;
    c      = ctrl_q[QBITS-1];
    clip_d = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      qv = q_q[QBITS-1][l];
      if (!c.neg[l]) begin
        sat      = c.ovf[l] || (qv > QBITS'(32'h7FFF_FFFF));
        res_d[l] = sat ? 32'sh7FFF_FFFF : qv[31:0];
      end else begin
        sat      = c.ovf[l] || (qv > QBITS'(32'h8000_0000));
        res_d[l] = sat ? 32'sh8000_0000 : 32'(-qv);
      end
      if (c.w_zero) begin
        res_d[l] = '0;
        sat      = 1'b0;
      end
      clip_d = clip_d | sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else if (en_i) begin
      fv_q <= v_q[QBITS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q  <= res_d;
      wz_q   <= ctrl_q[QBITS-1].w_zero;
      clip_q <= clip_d;
    end
  end

  assign valid_o      = fv_q;
  assign out_x_o      = res_q[0];
  assign out_y_o      = res_q[1];
  assign out_z_o      = res_q[2];
  assign w_was_zero_o = wz_q;
  assign clipped_o    = clip_q;

endmodule

/* src/point_transform_perspective_divide_core.sv */
// Pipeline: 37 register stages (3 transform stages, 33 divider stages of one quotient
//   bit each, 1 saturation stage); an accepted input transaction passes through them in
//   order, and out_valid_o rises when it reaches the saturation stage.
// Throughput: one transaction per cycle while out_ready_i stays high. A one-entry output
//   skid buffer catches the result that the sink refuses; from the next cycle the whole
//   pipe and in_ready_o hold until the sink takes the skid entry.
// Reset: rst_ni clears all valid bits and loads the matrix registers with identity.
module point_transform_perspective_divide_core #(
  parameter int unsigned FRAC_BITS = ptpd_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // point input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] in_x_i,
  input  logic signed [31:0] in_y_i,
  input  logic signed [31:0] in_z_i,
  // projected point output channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic               w_was_zero_o,
  output logic               clipped_o,
  // matrix register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);
  import ptpd_pkg::*;

  localparam int unsigned MW = DIV_W - FRAC_BITS;

  logic signed [31:0] coef [4][4];
  logic               adv;
  logic               xv;
  ptpd_ctrl_t         xctrl;
  logic [MW-1:0]      xmd;
  logic [MW-1:0]      xr0  [LANES];
  logic [QBITS-1:0]   xdlo [LANES];
  logic               fv;
  logic signed [31:0] fx, fy, fz;
  logic               fwz, fclip;

  // skid buffer: catch the last stage's result when the sink stalls
  logic               skid_v_q, skid_v_d;
  logic signed [31:0] skid_x_q, skid_y_q, skid_z_q;
  logic               skid_wz_q, skid_clip_q;
  logic               skid_load;

  ptpd_regs #(.FRAC_BITS(FRAC_BITS)) u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .coef_o(coef)
  );

  // The whole pipeline moves together; it freezes only while the skid holds a result.
  assign adv        = !skid_v_q;
  assign in_ready_o = adv;

  ptpd_xform #(.FRAC_BITS(FRAC_BITS), .MW(MW)) u_xform (
    .clk_i, .rst_ni,
    .en_i    (adv),
    .valid_i (in_valid_i),
    .in_x_i, .in_y_i, .in_z_i,
    .coef_i  (coef),
    .valid_o (xv),
    .ctrl_o  (xctrl),
    .md_o    (xmd),
    .r0_o    (xr0),
    .dlo_o   (xdlo)
  );

  ptpd_div #(.FRAC_BITS(FRAC_BITS), .MW(MW)) u_div (
    .clk_i, .rst_ni,
    .en_i         (adv),
    .valid_i      (xv),
    .ctrl_i       (xctrl),
    .md_i         (xmd),
    .r0_i         (xr0),
    .dlo_i        (xdlo),
    .valid_o      (fv),
    .out_x_o      (fx),
    .out_y_o      (fy),
    .out_z_o      (fz),
    .w_was_zero_o (fwz),
    .clipped_o    (fclip)
  );

  // Load the skid when a finished transaction is not taken while the pipe advances;
  // drain it once the sink takes it.
  assign skid_load = !skid_v_q && fv && !out_ready_i;

  always_comb begin
    skid_v_d = skid_v_q;
    if (skid_load) begin
      skid_v_d = 1'b1;
    end else if (skid_v_q && out_ready_i) begin
      skid_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else begin
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_load) begin
      skid_x_q    <= fx;
      skid_y_q    <= fy;
      skid_z_q    <= fz;
      skid_wz_q   <= fwz;
      skid_clip_q <= fclip;
    end
  end

  // The skid, when full, is older than the frozen last stage, so it goes out first.
  assign out_valid_o  = skid_v_q || fv;
  assign out_x_o      = skid_v_q ? skid_x_q    : fx;
  assign out_y_o      = skid_v_q ? skid_y_q    : fy;
  assign out_z_o      = skid_v_q ? skid_z_q    : fz;
  assign w_was_zero_o = skid_v_q ? skid_wz_q   : fwz;
  assign clipped_o    = skid_v_q ? skid_clip_q : fclip;

  // A held skid entry stays until the sink takes it.
  a_skid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && !out_ready_i |=> skid_v_q)
    else $error("skid entry dropped without handshake");

  // Zero w forces zero coordinates and no clip.
  a_wzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && w_was_zero_o |->
      out_x_o == 0 && out_y_o == 0 && out_z_o == 0 && !clipped_o)
    else $error("zero w result not forced to zero");

  // A clipped result has at least one coordinate at a range bound.
  a_clip_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clipped_o |->
      out_x_o == 32'sh7FFF_FFFF || out_x_o == 32'sh8000_0000 ||
      out_y_o == 32'sh7FFF_FFFF || out_y_o == 32'sh8000_0000 ||
      out_z_o == 32'sh7FFF_FFFF || out_z_o == 32'sh8000_0000)
    else $error("clip flag without saturated coordinate");

  // The skid fills only from a stalled valid last stage.
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !skid_v_q ##1 skid_v_q |-> $past(fv) && !$past(out_ready_i))
    else $error("skid filled without a stalled result");

endmodule
